// ===== rtl/uns_pkg.sv =====
// Shared constants, command type and hex helper for the URI name splitter.
package uns_pkg;

  // Component and length limits
  localparam int MaxComponents = 64;
  localparam int CompWidth     = 6;
  localparam int LenWidth      = 12;
  localparam logic [LenWidth-1:0] LenMax = '1;

  // Command queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrWidth  = $clog2(QueueDepth);
  localparam int QCntWidth  = $clog2(QueueDepth + 1);

  // Escape progress inside a component
  localparam logic [1:0] EscNone = 2'd0;
  localparam logic [1:0] EscPct  = 2'd1;
  localparam logic [1:0] EscHeld = 2'd2;

  // Character codes
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] CaseBit  = 8'h20;
  localparam logic [3:0] HexTen   = 4'd10;

  // One decoded request: up to two bytes, then an optional closing result
  typedef struct packed {
    logic [1:0]          nbytes;
    logic [7:0]          byte0;
    logic [7:0]          byte1;
    logic [CompWidth-1:0] idx;
    logic                tail;
    logic                tail_end;
    logic [LenWidth-1:0] len;
    logic                done;
    logic [CompWidth-1:0] cnt;
  } cmd_t;

  // Hex digit value; anything that is not a hex digit counts as zero
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] lc;
    logic [3:0] v;
    lc = (c >= ChUpperA && c <= ChUpperZ) ? (c | CaseBit) : c;
    if (c >= ChDigit0 && c <= ChDigit9) begin
      v = c[3:0];
    end else if (lc >= ChLowerA && lc <= ChLowerF) begin
      v = 4'(lc - ChLowerA) + HexTen;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

// ===== rtl/uri_name_splitter_unescaper_core.sv =====
// Top level: URI name splitter and percent decoder.
// Path: a character's command is stored in the command queue, then in the output register.
// Throughput: one character per cycle while each gives at most one result and the
//   output is not stalled; a character with two or three results emits them in turn,
//   and a four-entry command queue between front and back absorbs these bursts.
// Reset: rst_ni clears all control state at once; no clearing pass is needed.
module uri_name_splitter_unescaper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    ch_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          data_valid_o,
  output logic [7:0]                    data_byte_o,
  output logic [uns_pkg::CompWidth-1:0] comp_index_o,
  output logic                          comp_end_o,
  output logic [uns_pkg::LenWidth-1:0]  comp_length_o,
  output logic                          uri_done_o,
  output logic [uns_pkg::CompWidth-1:0] comp_count_o,
  output logic                          last_result_o
);
  import uns_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  cmd_t cmd_in;
  cmd_t cmd_head;

  // Classify characters
  uns_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // Decouple front and back
  uns_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (cmd_head)
  );

  // Emit results
  uns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_i        (cmd_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_valid_o  (data_valid_o),
    .data_byte_o   (data_byte_o),
    .comp_index_o  (comp_index_o),
    .comp_end_o    (comp_end_o),
    .comp_length_o (comp_length_o),
    .uri_done_o    (uri_done_o),
    .comp_count_o  (comp_count_o),
    .last_result_o (last_result_o)
  );

endmodule

// ===== rtl/uns_front.sv =====
// Front end: accepts characters, tracks split and escape state, builds commands.
module uns_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    ch_i,
  input  logic          last_i,
  input  logic          q_full_i,
  output logic          in_stall_o,
  output logic          push_o,
  output uns_pkg::cmd_t cmd_o
);
  import uns_pkg::*;

  logic                 at_start_q, at_start_d;
  logic                 comp_open_q, comp_open_d;
  logic [1:0]           esc_q, esc_d;
  logic [7:0]           held_q, held_d;
  logic [CompWidth-1:0] comp_cnt_q, comp_cnt_d;
  logic [LenWidth-1:0]  len_q, len_d;
  logic                 limit_q, limit_d;

  logic                 accept;
  logic                 skip;
  logic                 active;
  logic [1:0]           esc;
  logic [1:0]           esc_n;
  logic [LenWidth-1:0]  len;
  logic [LenWidth:0]    len_sum;
  logic [LenWidth-1:0]  len_n;
  logic [CompWidth:0]   cnt_inc;
  logic [1:0]           nb;
  logic [7:0]           b0, b1;
  logic                 close;

  assign accept     = in_valid_i & ~q_full_i;
  assign in_stall_o = q_full_i;

  // Classify the request against the current state
  always_comb begin
    skip    = at_start_q && (ch_i == ChSlash);
    active  = !skip && (comp_open_q || !limit_q);
    esc     = comp_open_q ? esc_q : EscNone;
    len     = comp_open_q ? len_q : '0;
    esc_n   = esc;
    held_d  = held_q;
    nb      = 2'd0;
    b0      = 8'd0;
    b1      = 8'd0;
    close   = 1'b0;
    if (active) begin
      if (ch_i == ChSlash) begin
        close = 1'b1;
        case (esc)
          EscPct: begin
            nb = 2'd1;
            b0 = ChPct;
          end
          EscHeld: begin
            nb = 2'd2;
            b0 = ChPct;
            b1 = held_q;
          end
          default: ;
        endcase
      end else begin
        case (esc)
          EscNone: begin
            if (ch_i == ChPct) begin
              esc_n = EscPct;
            end else begin
              nb = 2'd1;
              b0 = ch_i;
            end
          end
          EscPct: begin
            held_d = ch_i;
            esc_n  = EscHeld;
          end
          default: begin
            nb    = 2'd1;
            b0    = {hex_val(held_q), hex_val(ch_i)};
            esc_n = EscNone;
          end
        endcase
        // End of URI: flush a cut-short escape, then close
        if (last_i) begin
          close = 1'b1;
          if (esc_n == EscPct) begin
            nb = 2'd1;
            b0 = ChPct;
          end else if (esc_n == EscHeld) begin
            nb = 2'd2;
            b0 = ChPct;
            b1 = ch_i;
          end
        end
      end
    end
    len_sum = {1'b0, len} + (LenWidth+1)'(nb);
    len_n   = len_sum[LenWidth] ? LenMax : len_sum[LenWidth-1:0];
    cnt_inc = {1'b0, comp_cnt_q} + (CompWidth+1)'(1);
  end

  // Build the command for the back end
  always_comb begin
    cmd_o          = '0;
    cmd_o.nbytes   = nb;
    cmd_o.byte0    = b0;
    cmd_o.byte1    = b1;
    cmd_o.idx      = (close || nb != 2'd0) ? comp_cnt_q : '0;
    cmd_o.tail     = close | last_i;
    cmd_o.tail_end = close;
    cmd_o.len      = close ? len_n : '0;
    cmd_o.done     = last_i;
    if (last_i) begin
      cmd_o.cnt = close ? cnt_inc[CompWidth-1:0] : comp_cnt_q;
    end
    push_o = accept && (nb != 2'd0 || close || last_i);
  end

  // Advance the state
  always_comb begin
    at_start_d  = at_start_q;
    comp_open_d = comp_open_q;
    esc_d       = esc_q;
    comp_cnt_d  = comp_cnt_q;
    len_d       = len_q;
    limit_d     = limit_q;
    if (accept) begin
      at_start_d = 1'b0;
      if (active) begin
        comp_open_d = 1'b1;
        esc_d       = esc_n;
        len_d       = len_n;
      end
      if (close) begin
        comp_cnt_d  = cnt_inc[CompWidth-1:0];
        limit_d     = cnt_inc >= (CompWidth+1)'(MaxComponents - 1);
        comp_open_d = 1'b0;
        len_d       = '0;
        esc_d       = EscNone;
      end
      if (last_i) begin
        at_start_d  = 1'b1;
        comp_open_d = 1'b0;
        esc_d       = EscNone;
        comp_cnt_d  = '0;
        len_d       = '0;
        limit_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q  <= 1'b1;
      comp_open_q <= 1'b0;
      esc_q       <= EscNone;
      comp_cnt_q  <= '0;
      len_q       <= '0;
      limit_q     <= 1'b0;
    end else begin
      at_start_q  <= at_start_d;
      comp_open_q <= comp_open_d;
      esc_q       <= esc_d;
      comp_cnt_q  <= comp_cnt_d;
      len_q       <= len_d;
      limit_q     <= limit_d;
    end
  end

  // Hold the escaped character
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  // The last character always returns the splitter to its start state
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (at_start_q && !comp_open_q && comp_cnt_q == '0))
    else $error("splitter not back at start after last character");

  // Component count never passes the limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CompWidth+1)'(comp_cnt_q) <= (CompWidth+1)'(MaxComponents - 1))
    else $error("component count beyond limit");

endmodule

// ===== rtl/uns_cmd_fifo.sv =====
// Short command queue between the front and back ends.
module uns_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uns_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output uns_pkg::cmd_t cmd_o
);
  import uns_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] count_q, count_d;

  assign full_o  = count_q == QCntWidth'(QueueDepth);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Track the fill level
  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCntWidth'(1);
      2'b01:   count_d = count_q - QCntWidth'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrWidth'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrWidth'(1);
      end
      count_q <= count_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue underflow");

endmodule

// ===== rtl/uns_back.sv =====
// Back end: expands each command into one to three registered results.
module uns_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  uns_pkg::cmd_t                 head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          data_valid_o,
  output logic [7:0]                    data_byte_o,
  output logic [uns_pkg::CompWidth-1:0] comp_index_o,
  output logic                          comp_end_o,
  output logic [uns_pkg::LenWidth-1:0]  comp_length_o,
  output logic                          uri_done_o,
  output logic [uns_pkg::CompWidth-1:0] comp_count_o,
  output logic                          last_result_o
);
  import uns_pkg::*;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           pos_q, pos_d;
  logic                 data_valid_q;
  logic [7:0]           data_byte_q;
  logic [CompWidth-1:0] comp_index_q;
  logic                 comp_end_q;
  logic [LenWidth-1:0]  comp_length_q;
  logic                 uri_done_q;
  logic [CompWidth-1:0] comp_count_q;
  logic                 last_result_q;

  logic [1:0] n_res;
  logic       load;
  logic       is_last;
  logic       is_byte;

  // Step through the results of the head command
  always_comb begin
    n_res   = head_i.nbytes + {1'b0, head_i.tail};
    load    = head_valid_i && (!out_valid_q || !out_stall_i);
    is_last = pos_q == (n_res - 2'd1);
    is_byte = pos_q < head_i.nbytes;
    pop_o   = load && is_last;
    pos_d   = pos_q;
    if (load) begin
      pos_d = is_last ? 2'd0 : pos_q + 2'd1;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      comp_index_q  <= head_i.idx;
      last_result_q <= is_last;
      if (is_byte) begin
        data_valid_q  <= 1'b1;
        data_byte_q   <= pos_q[0] ? head_i.byte1 : head_i.byte0;
        comp_end_q    <= 1'b0;
        comp_length_q <= '0;
        uri_done_q    <= 1'b0;
        comp_count_q  <= '0;
      end else begin
        data_valid_q  <= 1'b0;
        data_byte_q   <= 8'd0;
        comp_end_q    <= head_i.tail_end;
        comp_length_q <= head_i.len;
        uri_done_q    <= head_i.done;
        comp_count_q  <= head_i.cnt;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_valid_o  = data_valid_q;
  assign data_byte_o   = data_byte_q;
  assign comp_index_o  = comp_index_q;
  assign comp_end_o    = comp_end_q;
  assign comp_length_o = comp_length_q;
  assign uri_done_o    = uri_done_q;
  assign comp_count_o  = comp_count_q;
  assign last_result_o = last_result_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (n_res != 2'd0 && pos_q < n_res))
    else $error("result position outside head command");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && last_result_q))
    else $error("command retired without last-result mark");

endmodule

// ===== sim/uri_name_splitter_unescaper_core_tb.sv =====
// Testbench for the URI name splitter and percent decoder core.
module uri_name_splitter_unescaper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uns_pkg::*;

  localparam int          HoldCycles = 60;
  localparam int          StuckLimit = 2000;
  localparam logic [7:0]  ChUpperF   = 8'h46;

  typedef struct packed {
    logic                 data_valid;
    logic [7:0]           data_byte;
    logic [CompWidth-1:0] comp_index;
    logic                 comp_end;
    logic [LenWidth-1:0]  comp_length;
    logic                 uri_done;
    logic [CompWidth-1:0] comp_count;
    logic                 last_result;
  } uri_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           ch_i;
  logic                 last_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 data_valid_o;
  logic [7:0]           data_byte_o;
  logic [CompWidth-1:0] comp_index_o;
  logic                 comp_end_o;
  logic [LenWidth-1:0]  comp_length_o;
  logic                 uri_done_o;
  logic [CompWidth-1:0] comp_count_o;
  logic                 last_result_o;

  uri_name_splitter_unescaper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_valid_o  (data_valid_o),
    .data_byte_o   (data_byte_o),
    .comp_index_o  (comp_index_o),
    .comp_end_o    (comp_end_o),
    .comp_length_o (comp_length_o),
    .uri_done_o    (uri_done_o),
    .comp_count_o  (comp_count_o),
    .last_result_o (last_result_o)
  );

  // Decoder state mirror
  logic                at_start;
  logic                comp_open;
  logic [1:0]          esc_state;
  logic [7:0]          held_ch;
  int                  comps_closed;
  logic [LenWidth-1:0] comp_len;
  logic                limit_hit;

  uri_result_t pending_results[$];
  uri_result_t got_result;
  uri_result_t want_result;
  int          mismatches;
  int          stuck_cycles;
  bit          idling_on;
  bit          long_hold_req;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_decoder();
    at_start     = 1'b1;
    comp_open    = 1'b0;
    esc_state    = EscNone;
    held_ch      = 8'h00;
    comps_closed = 0;
    comp_len     = '0;
    limit_hit    = 1'b0;
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= ChDigit0 && c <= ChDigit9) return 4'(c - ChDigit0);
    if (c >= ChLowerA && c <= ChLowerF) return 4'(c - ChLowerA + 8'd10);
    if (c >= ChUpperA && c <= ChUpperF) return 4'(c - ChUpperA + 8'd10);
    return 4'd0;
  endfunction

  function automatic void push_result(input logic dv, input logic [7:0] b,
                                      input int idx, input logic ce,
                                      input logic [LenWidth-1:0] len,
                                      input logic done, input int cnt);
    uri_result_t r;
    r.data_valid  = dv;
    r.data_byte   = b;
    r.comp_index  = CompWidth'(idx);
    r.comp_end    = ce;
    r.comp_length = len;
    r.uri_done    = done;
    r.comp_count  = CompWidth'(cnt);
    r.last_result = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void emit_decoded(input logic [7:0] b);
    push_result(1'b1, b, comps_closed, 1'b0, '0, 1'b0, 0);
    if (comp_len != LenMax) comp_len = comp_len + 1'b1;
  endfunction

  // Release a half-received escape as raw characters
  function automatic void flush_escape();
    if (esc_state == EscPct || esc_state == EscHeld) emit_decoded(ChPct);
    if (esc_state == EscHeld) emit_decoded(held_ch);
    esc_state = EscNone;
  endfunction

  function automatic void close_component(input logic done);
    int idx;
    idx          = comps_closed;
    comps_closed = comps_closed + 1;
    push_result(1'b0, 8'h00, idx, 1'b1, comp_len, done, done ? comps_closed : 0);
    if (comps_closed >= MaxComponents - 1) limit_hit = 1'b1;
    comp_open = 1'b0;
    comp_len  = '0;
    esc_state = EscNone;
  endfunction

  // Predict the results of one accepted character
  function automatic void decode_uri_char(input logic [7:0] c, input logic is_last);
    int          n0;
    logic        skip;
    logic        done_sent;
    uri_result_t r;
    n0        = pending_results.size();
    skip      = 1'b0;
    done_sent = 1'b0;
    if (at_start) begin
      at_start = 1'b0;
      if (c == ChSlash) skip = 1'b1;
    end
    if (!skip && (comp_open || !limit_hit)) begin
      if (!comp_open) begin
        comp_open = 1'b1;
        comp_len  = '0;
        esc_state = EscNone;
      end
      if (c == ChSlash) begin
        flush_escape();
        close_component(is_last);
        done_sent = is_last;
      end else if (esc_state == EscNone) begin
        if (c == ChPct) esc_state = EscPct;
        else emit_decoded(c);
      end else if (esc_state == EscPct) begin
        held_ch   = c;
        esc_state = EscHeld;
      end else begin
        emit_decoded({hex_nibble(held_ch), hex_nibble(c)});
        esc_state = EscNone;
      end
    end
    if (is_last) begin
      if (comp_open) begin
        flush_escape();
        close_component(1'b1);
      end else if (!done_sent) begin
        push_result(1'b0, 8'h00, 0, 1'b0, '0, 1'b1, comps_closed);
      end
      clear_decoder();
    end
    if (pending_results.size() > n0) begin
      r = pending_results.pop_back();
      r.last_result = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on accepted requests, then compare accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_uri_char(ch_i, last_i);
      if (out_valid_o && !out_stall_i) begin
        got_result.data_valid  = data_valid_o;
        got_result.data_byte   = data_byte_o;
        got_result.comp_index  = comp_index_o;
        got_result.comp_end    = comp_end_o;
        got_result.comp_length = comp_length_o;
        got_result.uri_done    = uri_done_o;
        got_result.comp_count  = comp_count_o;
        got_result.last_result = last_result_o;
        if (pending_results.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want_result = pending_results.pop_front();
          check_field("data_valid", want_result.data_valid, got_result.data_valid);
          check_field("data_byte", want_result.data_byte, got_result.data_byte);
          check_field("comp_index", want_result.comp_index, got_result.comp_index);
          check_field("comp_end", want_result.comp_end, got_result.comp_end);
          check_field("comp_length", want_result.comp_length, got_result.comp_length);
          check_field("uri_done", want_result.uri_done, got_result.uri_done);
          check_field("comp_count", want_result.comp_count, got_result.comp_count);
          check_field("last_result", want_result.last_result, got_result.last_result);
        end
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= StuckLimit) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one character and hold it until accepted; called at a falling edge
  task automatic send_char(input logic [7:0] c, input logic is_last);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Character mix that favors slashes, escapes and hex digits
  function automatic logic [7:0] pick_uri_char();
    int v;
    case ($urandom_range(0, 9))
      0, 1: return ChSlash;
      2:    return ChPct;
      3, 4: begin
        v = $urandom_range(0, 15);
        if (v < 10) return ChDigit0 + 8'(v);
        return ($urandom_range(0, 1) ? ChLowerA : ChUpperA) + 8'(v - 10);
      end
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic test_directed();
    send_text("/");
    send_text("/%4a//");
    send_text("%G");
    send_char(8'h00, 1'b0);
    send_char(ChPct, 1'b0);
    send_char(ChUpperF, 1'b0);
    send_char(ChSlash, 1'b0);
    send_char(ChPct, 1'b1);
    send_char(8'hFF, 1'b0);
    send_text("%9f%A0");
    send_text("%z1");
  endtask

  task automatic test_component_limit();
    for (int variant = 0; variant < 2; variant++) begin
      send_char(ChSlash, 1'b0);
      repeat (MaxComponents - 1) send_char(ChSlash, 1'b0);
      // Past the limit: drop everything until the final character
      send_text("ab%");
      send_char(variant == 0 ? 8'h63 : ChSlash, 1'b1);
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    send_text("/%41%42/x%4/%%%/q%e9/");
    send_text("ab%c");
  endtask

  task automatic test_random(input int item_goal);
    int sent;
    int n;
    sent = 0;
    while (sent < item_goal) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(20, 50);
        1:       n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      for (int i = 0; i < n; i++) begin
        // In every two-character URI the first character is pure noise
        if (n == 2 && i == 0) send_char(8'($urandom_range(1, 255)), 1'b0);
        else send_char(pick_uri_char(), i == n - 1);
      end
      sent = sent + n;
    end
  endtask

  initial begin
    mismatches    = 0;
    stuck_cycles  = 0;
    idling_on     = 1'b1;
    long_hold_req = 1'b0;
    clear_decoder();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    ch_i       <= 8'h00;
    last_i     <= 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_component_limit();
    test_backpressure();
    test_random(210);
    idling_on = 1'b0;
    test_random(50);

    // Drain the remaining results
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/uns_pkg.sv
rtl/uns_front.sv
rtl/uns_cmd_fifo.sv
rtl/uns_back.sv
rtl/uri_name_splitter_unescaper_core.sv
sim/uri_name_splitter_unescaper_core_tb.sv
